// ===== rtl/alac_pkg.sv =====
// Shared types, constants and saturating arithmetic for the affine-gap
// local alignment cell. No dependencies.
package alac_pkg;

    localparam int ALPHABET_SIZE   = 32;
    localparam int SCORE_WIDTH     = 16;
    localparam int RESIDUE_WIDTH   = $clog2(ALPHABET_SIZE);
    localparam int TABLE_DEPTH     = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int TABLE_ADDR_W    = 2 * RESIDUE_WIDTH;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAP_OPEN   = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAP_EXTEND = 1'd1;

    typedef enum logic {
        FUNC_COMPUTE = 1'b0,
        FUNC_LOAD    = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        DIR_DIAG = 2'd0,
        DIR_UP   = 2'd1,
        DIR_LEFT = 2'd2,
        DIR_END  = 2'd3
    } dir_t;

    typedef logic signed [SCORE_WIDTH-1:0] score_t;

    typedef struct packed {
        func_t                    func;
        logic [RESIDUE_WIDTH-1:0] query_residue;
        logic [RESIDUE_WIDTH-1:0] reference_residue;
        score_t                   up_main;
        score_t                   up_delete;
        score_t                   left_main;
        score_t                   left_insert;
        score_t                   diag_main;
        score_t                   table_value;
    } in_t;

    typedef struct packed {
        logic [SCORE_WIDTH-2:0] main_score;
        score_t                 insert_score;
        score_t                 delete_score;
        dir_t                   direction;
        logic                   insert_extended;
        logic                   delete_extended;
    } out_t;

    localparam score_t SCORE_MAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};
    localparam score_t SCORE_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};

    function automatic score_t sat_add(input score_t a, input score_t b);
        logic signed [SCORE_WIDTH:0] sum;
        sum = {a[SCORE_WIDTH-1], a} + {b[SCORE_WIDTH-1], b};
        if (sum[SCORE_WIDTH] != sum[SCORE_WIDTH-1]) begin
            return sum[SCORE_WIDTH] ? SCORE_MIN : SCORE_MAX;
        end
        return sum[SCORE_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/alac_score.sv =====
// Cell recurrence: insert/delete/match layers, floored max and traceback code.
// Pure combinational; uses alac_pkg.
module alac_score (
    input  alac_pkg::in_t    item,
    input  alac_pkg::score_t gap_open,
    input  alac_pkg::score_t gap_extend,
    input  alac_pkg::score_t table_entry,
    output alac_pkg::out_t   result
);

    alac_pkg::score_t ins_open, ins_ext, del_open, del_ext;
    alac_pkg::score_t ins, del, match, best_id, best_all, best;
    logic ins_from_open, del_from_open;

    always_comb begin
        ins_open = alac_pkg::sat_add(item.left_main, gap_open);
        ins_ext  = alac_pkg::sat_add(item.left_insert, gap_extend);
        del_open = alac_pkg::sat_add(item.up_main, gap_open);
        del_ext  = alac_pkg::sat_add(item.up_delete, gap_extend);
        match    = alac_pkg::sat_add(table_entry, item.diag_main);

        // extend wins ties
        ins_from_open = ins_open > ins_ext;
        del_from_open = del_open > del_ext;
        ins = ins_from_open ? ins_open : ins_ext;
        del = del_from_open ? del_open : del_ext;

        best_id  = (ins > del) ? ins : del;
        best_all = (best_id > match) ? best_id : match;
        best     = best_all[alac_pkg::SCORE_WIDTH-1] ? '0 : best_all;

        result.main_score      = best[alac_pkg::SCORE_WIDTH-2:0];
        result.insert_score    = ins;
        result.delete_score    = del;
        result.insert_extended = !ins_from_open;
        result.delete_extended = !del_from_open;
        if (best == ins) begin
            result.direction = alac_pkg::DIR_LEFT;
        end else if (best == del) begin
            result.direction = alac_pkg::DIR_UP;
        end else if (best == match) begin
            result.direction = alac_pkg::DIR_DIAG;
        end else begin
            result.direction = alac_pkg::DIR_END;
        end
    end

endmodule

// ===== rtl/affine_local_alignment_cell.sv =====
// A compute transaction is registered in stage 1, then in the result register.
// Throughput: one transaction per cycle unless m_ready stalls the output; the
// substitution table read is the only pipeline stage ahead of the result register.
// Load transactions write the table and produce no result.
// Reset (aresetn low, synchronous) clears pipeline valids and gap scores;
// table contents stay undefined until written.
module affine_local_alignment_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [alac_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [alac_pkg::SCORE_WIDTH-1:0]     cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  alac_pkg::in_t                        s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output alac_pkg::out_t                       m_payload
);

    alac_pkg::score_t gap_open_reg, gap_extend_reg;

    alac_pkg::score_t table_mem [alac_pkg::TABLE_DEPTH];
    alac_pkg::score_t rd_data_reg;

    logic           s1_valid_reg;
    alac_pkg::in_t  s1_item_reg;
    logic           m_valid_reg;
    alac_pkg::out_t m_payload_reg;
    alac_pkg::out_t result;

    logic s_accept, out_free, s1_advance, compute_accept, load_accept;
    logic [alac_pkg::TABLE_ADDR_W-1:0] table_addr;

    assign out_free       = !m_valid_reg || m_ready;
    assign s1_advance     = s1_valid_reg && out_free;
    assign s_ready        = !s1_valid_reg || out_free;
    assign s_accept       = s_valid && s_ready;
    assign compute_accept = s_accept && (s_payload.func == alac_pkg::FUNC_COMPUTE);
    assign load_accept    = s_accept && (s_payload.func == alac_pkg::FUNC_LOAD);
    assign table_addr     = {s_payload.query_residue, s_payload.reference_residue};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_open_reg   <= '0;
            gap_extend_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                alac_pkg::REG_GAP_OPEN:   gap_open_reg   <= cfg_wr_data;
                alac_pkg::REG_GAP_EXTEND: gap_extend_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Read data only updates on a compute accept, so it holds while stage 1 stalls.
    always_ff @(posedge aclk) begin
        if (load_accept) begin
            table_mem[table_addr] <= s_payload.table_value;
        end
        if (compute_accept) begin
            rd_data_reg <= table_mem[table_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (compute_accept) begin
            s1_item_reg <= s_payload;
        end
        if (s1_advance) begin
            m_payload_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= compute_accept;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    alac_score u_score (
        .item        (s1_item_reg),
        .gap_open    (gap_open_reg),
        .gap_extend  (gap_extend_reg),
        .table_entry (rd_data_reg),
        .result      (result)
    );

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef NO_ASSERTIONS
    a_end_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.direction == alac_pkg::DIR_END)
            |-> (m_payload_reg.main_score == '0))
        else $error("end direction with nonzero main score");

    a_left_matches_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_payload_reg.direction == alac_pkg::DIR_LEFT)
            |-> ({1'b0, m_payload_reg.main_score} == m_payload_reg.insert_score))
        else $error("left direction but main score differs from insert score");

    a_compute_enters_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        compute_accept |=> s1_valid_reg)
        else $error("accepted compute transaction lost before stage 1");

    a_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free)
            |=> (s1_valid_reg && $stable(s1_item_reg) && $stable(rd_data_reg)))
        else $error("stalled stage 1 transaction changed");
`endif

endmodule
